// File: rtl/damped_spring_force_assert.svh
// Assertion macros shared by the damped spring force checkers
`ifndef DAMPED_SPRING_FORCE_ASSERT_SVH
`define DAMPED_SPRING_FORCE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DSF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define DSF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dsf_pkg.sv
// Shared widths, register codes and constants of the damped spring force block
package dsf_pkg;

    localparam int POS_W     = 32;
    localparam int DIFF_W    = POS_W + 1;
    localparam int MAG_W     = POS_W;
    localparam int DT_W      = 31;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = 32;
    localparam int ROOT_W    = 32;

    localparam logic [CFG_W-1:0] MASS_ONE = CFG_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STIFFNESS   = 3'd0,
        CFG_DAMPING     = 3'd1,
        CFG_REST_LENGTH = 3'd2,
        CFG_MASS_A      = 3'd3,
        CFG_MASS_B      = 3'd4
    } cfg_idx_t;

endpackage

// File: rtl/dsf_dly.sv
// Enabled shift line that delays a payload word by a fixed number of stages
module dsf_dly #(
    parameter int DW    = 8,
    parameter int DEPTH = 1
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] d,
    output logic [DW-1:0] q
);

    logic [DW-1:0] stage_reg [DEPTH];

    // Advance the line when the pipeline moves
    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++) begin
                stage_reg[i] <= stage_reg[i-1];
            end
        end
    end

    assign q = stage_reg[DEPTH-1];

endmodule

// File: rtl/dsf_div.sv
// Pipelined restoring divider, one quotient bit per stage
module dsf_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int Q_W   = 18
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   q
);

    localparam int CW = NUM_W + DEN_W;

    logic [NUM_W-1:0] rem_reg [Q_W-1];
    logic [DEN_W-1:0] den_reg [Q_W-1];
    logic [Q_W-1:0]   q_reg   [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stg
        localparam int SH = Q_W - 1 - s;
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [Q_W-1:0]   q_in;
        logic [CW-1:0]    trial;
        logic             take;

        if (s == 0) begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        // Try to subtract the shifted divisor
        assign trial = CW'(den_in) << SH;
        assign take  = CW'(rem_in) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[s] <= q_in | (take ? (Q_W'(1) << SH) : '0);
            end
        end

        if (s < Q_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s] <= take ? NUM_W'(CW'(rem_in) - trial) : rem_in;
                    den_reg[s] <= den_in;
                end
            end
        end
    end

    assign q = q_reg[Q_W-1];

endmodule

// File: rtl/dsf_sqrt.sv
// Pipelined integer square root, one root bit per stage
module dsf_sqrt
    import dsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   x,
    output logic [ROOT_W-1:0]     root
);

    localparam int XW = 2 * ROOT_W;
    localparam int TW = XW + 1;

    logic [XW-1:0]     rem_reg [ROOT_W-1];
    logic [ROOT_W-1:0] res_reg [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stg
        localparam int BI = ROOT_W - 1 - s;
        logic [XW-1:0]     rem_in;
        logic [ROOT_W-1:0] res_in;
        logic [TW-1:0]     trial;
        logic              take;

        if (s == 0) begin : g_first
            assign rem_in = x;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign res_in = res_reg[s-1];
        end

        // (res + 2^i)^2 - res^2 against the remaining value
        assign trial = (TW'(res_in) << (BI + 1)) + (TW'(1) << (2 * BI));
        assign take  = TW'(rem_in) >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                res_reg[s] <= res_in | (take ? (ROOT_W'(1) << BI) : '0);
            end
        end

        if (s < ROOT_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s] <= take ? XW'(TW'(rem_in) - trial) : rem_in;
                end
            end
        end
    end

    assign root = res_reg[ROOT_W-1];

endmodule

// File: rtl/dsf_mulq.sv
// Two-stage fixed-point multiply: truncate toward zero, saturate to the word
module dsf_mulq #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output logic signed [W-1:0]  p
);

    localparam int PW = AW + BW;

    logic [AW-1:0]       amag;
    logic [BW-1:0]       bmag;
    logic                neg_next;
    logic [PW-1:0]       prod_reg;
    logic                neg_reg;
    logic [PW-1:0]       shr;
    logic [PW-1:0]       lim;
    logic [PW-1:0]       mag_sat;
    logic [W-1:0]        p_next;
    logic signed [W-1:0] p_reg;

    // Split into sign and magnitudes
    assign amag     = a[AW-1] ? AW'(-a) : AW'(a);
    assign bmag     = b[BW-1] ? BW'(-b) : BW'(b);
    assign neg_next = a[AW-1] ^ b[BW-1];

    // Drop the fraction and clamp the magnitude
    always_comb begin
        shr     = prod_reg >> F;
        lim     = neg_reg ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
        mag_sat = (shr > lim) ? lim : shr;
        p_next  = neg_reg ? W'(-mag_sat) : W'(mag_sat);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PW'(amag) * PW'(bmag);
            neg_reg  <= neg_next;
            p_reg    <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: rtl/damped_spring_force.sv
// Damped spring force pipeline between two bodies, Q(FRAC_BITS) fixed point.
// The square root (32 stages) and direction divider (FRAC_BITS + 2 stages) lie in
// series on the path from input transfer to result.
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Reset: clears all valid bits and loads register defaults (masses 1.0, rest 0).
module damped_spring_force
    import dsf_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [POS_W-1:0] s_pos_a_x,
    input  logic signed [POS_W-1:0] s_pos_a_y,
    input  logic signed [POS_W-1:0] s_prev_a_x,
    input  logic signed [POS_W-1:0] s_prev_a_y,
    input  logic signed [POS_W-1:0] s_pos_b_x,
    input  logic signed [POS_W-1:0] s_pos_b_y,
    input  logic signed [POS_W-1:0] s_prev_b_x,
    input  logic signed [POS_W-1:0] s_prev_b_y,
    input  logic [DT_W-1:0]         s_time_step,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_force_a_x,
    output logic signed [OUT_W-1:0] m_force_a_y,
    output logic signed [OUT_W-1:0] m_force_b_x,
    output logic signed [OUT_W-1:0] m_force_b_y,
    output logic                    m_degenerate
);

    localparam int F   = FRAC_BITS;
    localparam int W   = WORD_BITS;
    localparam int XW  = W + F + 36;
    localparam int LAT = F + 46;
    localparam int UQ  = F + 2;
    localparam int VQ  = MAG_W + F;
    localparam int OQ  = 32;
    localparam int SQ_W = 2 * ROOT_W;

    // Saturate to the internal word
    function automatic logic signed [W-1:0] satw(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
        lo = ~hi;
        if (x > hi) return hi[W-1:0];
        else if (x < lo) return lo[W-1:0];
        else return x[W-1:0];
    endfunction

    // Saturate to the output width
    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = {{(XW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
        lo = ~hi;
        if (x > hi) return hi[OUT_W-1:0];
        else if (x < lo) return lo[OUT_W-1:0];
        else return x[OUT_W-1:0];
    endfunction

    // Apply a sign to a magnitude
    function automatic logic signed [XW-1:0] sgnm(input logic neg, input logic [XW-1:0] m);
        return neg ? -signed'(m) : signed'(m);
    endfunction

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] stiffness_reg;
    logic [CFG_W-1:0] damping_reg;
    logic [CFG_W-1:0] rest_length_reg;
    logic [CFG_W-1:0] mass_a_reg;
    logic [CFG_W-1:0] mass_b_reg;
    logic [CFG_W-1:0] ma_eff;
    logic [CFG_W-1:0] mb_eff;
    logic [CFG_W:0]   msum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiffness_reg   <= '0;
            damping_reg     <= '0;
            rest_length_reg <= '0;
            mass_a_reg      <= MASS_ONE;
            mass_b_reg      <= MASS_ONE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STIFFNESS:   stiffness_reg   <= cfg_data;
                CFG_DAMPING:     damping_reg     <= cfg_data;
                CFG_REST_LENGTH: rest_length_reg <= cfg_data;
                CFG_MASS_A:      mass_a_reg      <= cfg_data;
                CFG_MASS_B:      mass_b_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // Treat a zero mass as the smallest step
    assign ma_eff = (mass_a_reg == '0) ? CFG_W'(1) : mass_a_reg;
    assign mb_eff = (mass_b_reg == '0) ? CFG_W'(1) : mass_b_reg;
    assign msum   = {1'b0, ma_eff} + {1'b0, mb_eff};

    // ---------------- flow control ----------------
    logic           en;
    logic [LAT-1:0] vld_reg;

    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    // ---------------- stage 1: differences ----------------
    logic signed [DIFF_W-1:0] vx_next, vy_next;
    logic signed [DIFF_W-1:0] dn_next [4];
    logic signed [DIFF_W-1:0] vx_reg, vy_reg;
    logic [MAG_W-1:0]         ax_reg, ay_reg;
    logic [MAG_W-1:0]         nm_reg [4];
    logic [3:0]               ns_reg;
    logic [DT_W-1:0]          dt_reg;

    assign vx_next    = DIFF_W'(s_pos_b_x) - DIFF_W'(s_pos_a_x);
    assign vy_next    = DIFF_W'(s_pos_b_y) - DIFF_W'(s_pos_a_y);
    assign dn_next[0] = DIFF_W'(s_pos_a_x) - DIFF_W'(s_prev_a_x);
    assign dn_next[1] = DIFF_W'(s_pos_a_y) - DIFF_W'(s_prev_a_y);
    assign dn_next[2] = DIFF_W'(s_pos_b_x) - DIFF_W'(s_prev_b_x);
    assign dn_next[3] = DIFF_W'(s_pos_b_y) - DIFF_W'(s_prev_b_y);

    always_ff @(posedge aclk) begin
        if (en) begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
            ax_reg <= vx_next[DIFF_W-1] ? MAG_W'(-vx_next) : MAG_W'(vx_next);
            ay_reg <= vy_next[DIFF_W-1] ? MAG_W'(-vy_next) : MAG_W'(vy_next);
            for (int j = 0; j < 4; j++) begin
                nm_reg[j] <= dn_next[j][DIFF_W-1] ? MAG_W'(-dn_next[j])
                                                  : MAG_W'(dn_next[j]);
                ns_reg[j] <= dn_next[j][DIFF_W-1];
            end
            dt_reg <= (s_time_step == '0) ? DT_W'(1) : s_time_step;
        end
    end

    // ---------------- stages 2-4: scale, square, sum ----------------
    logic                 sh_reg;
    logic [MAG_W-2:0]     axn_reg, ayn_reg;
    logic [2*MAG_W-2:0]   mbax_reg, mbay_reg;
    logic [2*MAG_W-2:0]   lmb_reg;
    logic [2*MAG_W-3:0]   sqx_reg, sqy_reg;
    logic [SQ_W-1:0]      sum_reg;
    logic                 sh_next;

    assign sh_next = ax_reg[MAG_W-1] | ay_reg[MAG_W-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sh_reg   <= sh_next;
            axn_reg  <= sh_next ? ax_reg[MAG_W-1:1] : ax_reg[MAG_W-2:0];
            ayn_reg  <= sh_next ? ay_reg[MAG_W-1:1] : ay_reg[MAG_W-2:0];
            mbax_reg <= (2*MAG_W-1)'(mb_eff) * (2*MAG_W-1)'(ax_reg);
            mbay_reg <= (2*MAG_W-1)'(mb_eff) * (2*MAG_W-1)'(ay_reg);
            lmb_reg  <= (2*MAG_W-1)'(rest_length_reg) * (2*MAG_W-1)'(mb_eff);
            sqx_reg  <= (2*MAG_W-2)'(axn_reg) * (2*MAG_W-2)'(axn_reg);
            sqy_reg  <= (2*MAG_W-2)'(ayn_reg) * (2*MAG_W-2)'(ayn_reg);
            sum_reg  <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
        end
    end

    // ---------------- separation length ----------------
    logic [ROOT_W-1:0] root;
    logic              sh36;
    logic [ROOT_W:0]   len_reg;
    logic              deg_reg;

    dsf_sqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .x    (sum_reg),
        .root (root)
    );

    dsf_dly #(.DW(1), .DEPTH(34)) u_dly_sh (
        .aclk (aclk), .en (en), .d (sh_reg), .q (sh36)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            len_reg <= sh36 ? {root, 1'b0} : {1'b0, root};
            deg_reg <= (root == '0);
        end
    end

    // ---------------- separation delay line ----------------
    logic [2*DIFF_W-1:0] vv34, vv37, vv39, vv42;
    logic [2*MAG_W-1:0]  axy37;

    dsf_dly #(.DW(2*DIFF_W), .DEPTH(33)) u_dly_v34 (
        .aclk (aclk), .en (en), .d ({vx_reg, vy_reg}), .q (vv34)
    );
    dsf_dly #(.DW(2*DIFF_W), .DEPTH(3)) u_dly_v37 (
        .aclk (aclk), .en (en), .d (vv34), .q (vv37)
    );
    dsf_dly #(.DW(2*DIFF_W), .DEPTH(UQ)) u_dly_v39 (
        .aclk (aclk), .en (en), .d (vv37), .q (vv39)
    );
    dsf_dly #(.DW(2*DIFF_W), .DEPTH(3)) u_dly_v42 (
        .aclk (aclk), .en (en), .d (vv39), .q (vv42)
    );
    dsf_dly #(.DW(2*MAG_W), .DEPTH(36)) u_dly_a37 (
        .aclk (aclk), .en (en), .d ({ax_reg, ay_reg}), .q (axy37)
    );

    // ---------------- mass split of offset and rest length ----------------
    logic [OQ-1:0]            offx_q, offy_q, r1_q;
    logic signed [DIFF_W-1:0] offx_reg, offy_reg;
    logic [CFG_W-1:0]         r1_reg, r2_reg;
    logic [2*CFG_W-1:0]       r12_d;
    logic [2*DIFF_W-1:0]      off_d;

    dsf_div #(.NUM_W(2*MAG_W-1), .DEN_W(CFG_W+1), .Q_W(OQ)) u_div_offx (
        .aclk (aclk), .en (en), .num (mbax_reg), .den (msum), .q (offx_q)
    );
    dsf_div #(.NUM_W(2*MAG_W-1), .DEN_W(CFG_W+1), .Q_W(OQ)) u_div_offy (
        .aclk (aclk), .en (en), .num (mbay_reg), .den (msum), .q (offy_q)
    );
    dsf_div #(.NUM_W(2*MAG_W-1), .DEN_W(CFG_W+1), .Q_W(OQ)) u_div_r1 (
        .aclk (aclk), .en (en), .num (lmb_reg), .den (msum), .q (r1_q)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            offx_reg <= vv34[2*DIFF_W-1] ? -DIFF_W'(offx_q) : DIFF_W'(offx_q);
            offy_reg <= vv34[DIFF_W-1]   ? -DIFF_W'(offy_q) : DIFF_W'(offy_q);
            r1_reg   <= r1_q[CFG_W-1:0];
            r2_reg   <= rest_length_reg - r1_q[CFG_W-1:0];
        end
    end

    dsf_dly #(.DW(2*CFG_W), .DEPTH(F+5)) u_dly_r12 (
        .aclk (aclk), .en (en), .d ({r1_reg, r2_reg}), .q (r12_d)
    );
    dsf_dly #(.DW(2*DIFF_W), .DEPTH(F+7)) u_dly_off (
        .aclk (aclk), .en (en), .d ({offx_reg, offy_reg}), .q (off_d)
    );

    // ---------------- unit direction ----------------
    logic [UQ-1:0]       ux_q, uy_q;
    logic                deg39, deg45;
    logic signed [W-1:0] ux_reg, uy_reg;

    dsf_div #(.NUM_W(MAG_W+F), .DEN_W(ROOT_W+1), .Q_W(UQ)) u_div_ux (
        .aclk (aclk), .en (en), .num ({axy37[2*MAG_W-1:MAG_W], F'(0)}),
        .den (len_reg), .q (ux_q)
    );
    dsf_div #(.NUM_W(MAG_W+F), .DEN_W(ROOT_W+1), .Q_W(UQ)) u_div_uy (
        .aclk (aclk), .en (en), .num ({axy37[MAG_W-1:0], F'(0)}),
        .den (len_reg), .q (uy_q)
    );

    dsf_dly #(.DW(1), .DEPTH(UQ)) u_dly_deg39 (
        .aclk (aclk), .en (en), .d (deg_reg), .q (deg39)
    );
    dsf_dly #(.DW(1), .DEPTH(6)) u_dly_deg45 (
        .aclk (aclk), .en (en), .d (deg39), .q (deg45)
    );

    // Zero direction when the bodies coincide
    always_ff @(posedge aclk) begin
        if (en) begin
            ux_reg <= deg39 ? '0 : satw(sgnm(vv39[2*DIFF_W-1], XW'(ux_q)));
            uy_reg <= deg39 ? '0 : satw(sgnm(vv39[DIFF_W-1], XW'(uy_q)));
        end
    end

    // ---------------- displacement from rest ----------------
    logic signed [W-1:0]      m1 [4];
    logic signed [W-1:0]      d_reg [4];
    logic signed [DIFF_W-1:0] vx42, vy42, offx42, offy42;

    for (genvar j = 0; j < 4; j++) begin : g_mul1
        logic signed [W-1:0] u_sel;
        logic signed [31:0]  r_sel;
        assign u_sel = (j % 2 == 1) ? uy_reg : ux_reg;
        assign r_sel = (j / 2 == 1) ? signed'({1'b0, r12_d[CFG_W-1:0]})
                                    : signed'({1'b0, r12_d[2*CFG_W-1:CFG_W]});
        dsf_mulq #(.W(W), .F(F), .AW(W), .BW(32)) u_mul (
            .aclk (aclk), .en (en), .a (u_sel), .b (r_sel), .p (m1[j])
        );
    end

    assign vx42   = signed'(vv42[2*DIFF_W-1:DIFF_W]);
    assign vy42   = signed'(vv42[DIFF_W-1:0]);
    assign offx42 = signed'(off_d[2*DIFF_W-1:DIFF_W]);
    assign offy42 = signed'(off_d[DIFF_W-1:0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= satw(XW'(m1[0]) - XW'(offx42));
            d_reg[1] <= satw(XW'(m1[1]) - XW'(offy42));
            d_reg[2] <= satw(XW'(vx42) - XW'(offx42) - XW'(m1[2]));
            d_reg[3] <= satw(XW'(vy42) - XW'(offy42) - XW'(m1[3]));
        end
    end

    // ---------------- spring term ----------------
    logic signed [W-1:0] mk [4];
    logic signed [31:0]  k_s;

    assign k_s = signed'({1'b0, stiffness_reg});

    for (genvar j = 0; j < 4; j++) begin : g_mul2
        dsf_mulq #(.W(W), .F(F), .AW(32), .BW(W)) u_mul (
            .aclk (aclk), .en (en), .a (k_s), .b (d_reg[j]), .p (mk[j])
        );
    end

    // ---------------- velocities and damping term ----------------
    logic [VQ-1:0]       vq [4];
    logic [3:0]          ns_d;
    logic signed [W-1:0] va_reg [4];
    logic signed [W-1:0] rel_reg [2];
    logic signed [W-1:0] mc [2];
    logic signed [31:0]  c_s;
    logic [2*W-1:0]      mc_d;
    logic signed [W-1:0] mcx, mcy;

    for (genvar j = 0; j < 4; j++) begin : g_vdiv
        dsf_div #(.NUM_W(MAG_W+F), .DEN_W(DT_W), .Q_W(VQ)) u_div (
            .aclk (aclk), .en (en), .num ({nm_reg[j], F'(0)}), .den (dt_reg), .q (vq[j])
        );
    end

    dsf_dly #(.DW(4), .DEPTH(VQ)) u_dly_ns (
        .aclk (aclk), .en (en), .d (ns_reg), .q (ns_d)
    );

    // Hold the velocities, then relative velocity of A against B
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                va_reg[j] <= satw(sgnm(ns_d[j], XW'(vq[j])));
            end
            rel_reg[0] <= satw(XW'(va_reg[0]) - XW'(va_reg[2]));
            rel_reg[1] <= satw(XW'(va_reg[1]) - XW'(va_reg[3]));
        end
    end

    assign c_s = signed'({1'b0, damping_reg});

    for (genvar j = 0; j < 2; j++) begin : g_mulc
        dsf_mulq #(.W(W), .F(F), .AW(32), .BW(W)) u_mul (
            .aclk (aclk), .en (en), .a (c_s), .b (rel_reg[j]), .p (mc[j])
        );
    end

    dsf_dly #(.DW(2*W), .DEPTH(8)) u_dly_mc (
        .aclk (aclk), .en (en), .d ({mc[0], mc[1]}), .q (mc_d)
    );

    assign mcx = signed'(mc_d[2*W-1:W]);
    assign mcy = signed'(mc_d[W-1:0]);

    // ---------------- output register ----------------
    logic signed [OUT_W-1:0] force_a_x_reg, force_a_y_reg;
    logic signed [OUT_W-1:0] force_b_x_reg, force_b_y_reg;
    logic                    degenerate_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            force_a_x_reg  <= sat32(XW'(satw(-XW'(mk[0]) - XW'(mcx))));
            force_a_y_reg  <= sat32(XW'(satw(-XW'(mk[1]) - XW'(mcy))));
            force_b_x_reg  <= sat32(XW'(satw(-XW'(mk[2]) + XW'(mcx))));
            force_b_y_reg  <= sat32(XW'(satw(-XW'(mk[3]) + XW'(mcy))));
            degenerate_reg <= deg45;
        end
    end

    assign m_force_a_x  = force_a_x_reg;
    assign m_force_a_y  = force_a_y_reg;
    assign m_force_b_x  = force_b_x_reg;
    assign m_force_b_y  = force_b_y_reg;
    assign m_degenerate = degenerate_reg;

endmodule

// File: rtl/dsf_chk.sv
// Port-level checker for the damped spring force block, with its bind
`include "damped_spring_force_assert.svh"

module dsf_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_force_a_x,
    input logic [31:0] m_force_a_y,
    input logic [31:0] m_force_b_x,
    input logic [31:0] m_force_b_y,
    input logic        m_degenerate
);

    // Hold a stalled result
    `DSF_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_force_a_x) && $stable(m_force_b_y) && $stable(m_degenerate), "result changed while stalled")

    // An empty output slot always lets a transfer in
    `DSF_ASSERT_SAME(a_empty_ready, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output")

    // Coinciding bodies leave only opposite damping forces
    `DSF_ASSERT_SAME(a_deg_x, aclk, aresetn, m_valid && m_degenerate, (m_force_a_x == 32'(-m_force_b_x)) || (m_force_a_x == 32'h8000_0000) || (m_force_b_x == 32'h8000_0000), "degenerate x forces not opposite")
    `DSF_ASSERT_SAME(a_deg_y, aclk, aresetn, m_valid && m_degenerate, (m_force_a_y == 32'(-m_force_b_y)) || (m_force_a_y == 32'h8000_0000) || (m_force_b_y == 32'h8000_0000), "degenerate y forces not opposite")

endmodule

bind damped_spring_force dsf_chk u_dsf_chk (.*);

// File: bench/damped_spring_force_tb.sv
// Self-checking testbench for the damped spring force pipeline
module damped_spring_force_tb;
    import dsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC       = 16;
    localparam int  DRAIN_CYC  = 120;
    localparam int  CYCLE_MAX  = 600000;
    localparam longint WPOS    = 64'sd2147483647;
    localparam longint WNEG    = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] pax, pay, qax, qay, pbx, pby, qbx, qby;
        logic [DT_W-1:0]    dt;
    } spring_item_t;

    typedef struct {
        logic signed [31:0] fax, fay, fbx, fby;
        logic               deg;
    } spring_force_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [POS_W-1:0] s_pos_a_x = '0, s_pos_a_y = '0, s_prev_a_x = '0, s_prev_a_y = '0;
    logic signed [POS_W-1:0] s_pos_b_x = '0, s_pos_b_y = '0, s_prev_b_x = '0, s_prev_b_y = '0;
    logic [DT_W-1:0]         s_time_step = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_force_a_x, m_force_a_y, m_force_b_x, m_force_b_y;
    logic                    m_degenerate;

    // shadow copy of the configuration registers
    longint unsigned k_reg = 0, c_reg = 0, rest_reg = 0;
    longint unsigned ma_reg = 65536, mb_reg = 65536;

    spring_force_t force_q[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  err_count = 0;
    int  cycle_count = 0;

    damped_spring_force u_dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---------------- predictor ----------------
    function automatic longint sat_word(longint x);
        if (x > WPOS) return WPOS;
        if (x < WNEG) return WNEG;
        return x;
    endfunction

    function automatic longint unsigned abs_val(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    // product truncated toward zero and saturated to the word
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0]    p;
        logic [127:0]    lim;
        bit              neg;
        neg = (a < 0) != (b < 0);
        p = 128'(abs_val(a)) * 128'(abs_val(b));
        p = p >> FRAC;
        lim = neg ? 128'(64'd2147483648) : 128'(64'd2147483647);
        if (p > lim) p = lim;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint fx_div(longint num, longint unsigned den);
        longint unsigned q;
        q = (abs_val(num) << FRAC) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clip32(longint x);
        longint y;
        y = sat_word(x);
        return y[31:0];
    endfunction

    function automatic spring_force_t spring_forces(spring_item_t it);
        spring_force_t   f;
        longint unsigned dt, ma, mb, msum, ax, ay, len;
        longint          vx, vy, ux, uy, r1, r2, offx, offy, d1x, d1y, d2x, d2y, relx, rely;
        int              sh;
        dt = (it.dt == 0) ? 1 : longint'(it.dt);
        ma = (ma_reg == 0) ? 1 : ma_reg;
        mb = (mb_reg == 0) ? 1 : mb_reg;
        msum = ma + mb;
        vx = longint'(it.pbx) - longint'(it.pax);
        vy = longint'(it.pby) - longint'(it.pay);
        ax = abs_val(vx);
        ay = abs_val(vy);
        sh = 0;
        ux = 0;
        uy = 0;
        while (((ax | ay) >> 31) != 0) begin
            ax >>= 1;
            ay >>= 1;
            sh++;
        end
        len = int_sqrt(ax * ax + ay * ay) << sh;
        f.deg = (len == 0);
        if (!f.deg) begin
            ux = sat_word(fx_div(vx, len));
            uy = sat_word(fx_div(vy, len));
        end
        // split the rest length by mass ratio around the centre
        r1 = longint'((rest_reg * mb) / msum);
        r2 = longint'(rest_reg) - r1;
        offx = longint'((mb * abs_val(vx)) / msum);
        if (vx < 0) offx = -offx;
        offy = longint'((mb * abs_val(vy)) / msum);
        if (vy < 0) offy = -offy;
        d1x = sat_word(fx_mul(ux, r1) - offx);
        d1y = sat_word(fx_mul(uy, r1) - offy);
        d2x = sat_word(vx - offx - fx_mul(ux, r2));
        d2y = sat_word(vy - offy - fx_mul(uy, r2));
        relx = sat_word(sat_word(fx_div(longint'(it.pax) - longint'(it.qax), dt))
                      - sat_word(fx_div(longint'(it.pbx) - longint'(it.qbx), dt)));
        rely = sat_word(sat_word(fx_div(longint'(it.pay) - longint'(it.qay), dt))
                      - sat_word(fx_div(longint'(it.pby) - longint'(it.qby), dt)));
        f.fax = clip32(-fx_mul(k_reg, d1x) - fx_mul(c_reg, relx));
        f.fay = clip32(-fx_mul(k_reg, d1y) - fx_mul(c_reg, rely));
        f.fbx = clip32(-fx_mul(k_reg, d2x) + fx_mul(c_reg, relx));
        f.fby = clip32(-fx_mul(k_reg, d2y) + fx_mul(c_reg, rely));
        return f;
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want,
                 cycle_count);
        err_count++;
    endtask

    always @(posedge aclk) begin
        spring_force_t want;
        if (aresetn && m_valid && m_ready) begin
            if (force_q.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = force_q.pop_front();
                if (m_force_a_x !== want.fax) report_mismatch("force_a_x", m_force_a_x, want.fax);
                if (m_force_a_y !== want.fay) report_mismatch("force_a_y", m_force_a_y, want.fay);
                if (m_force_b_x !== want.fbx) report_mismatch("force_b_x", m_force_b_x, want.fbx);
                if (m_force_b_y !== want.fby) report_mismatch("force_b_y", m_force_b_y, want.fby);
                if (m_degenerate !== want.deg) report_mismatch("degenerate", m_degenerate, want.deg);
            end
        end
    end

    // receiver stall
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("damped_spring_force verification failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    // valid stays high after a transfer until an idle cycle or a drain drops it
    task automatic send_item(spring_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_pos_a_x   <= it.pax;
        s_pos_a_y   <= it.pay;
        s_prev_a_x  <= it.qax;
        s_prev_a_y  <= it.qay;
        s_pos_b_x   <= it.pbx;
        s_pos_b_y   <= it.pby;
        s_prev_b_x  <= it.qbx;
        s_prev_b_y  <= it.qby;
        s_time_step <= it.dt;
        do @(posedge aclk); while (!s_ready);
        force_q.push_back(spring_forces(it));
    endtask

    // write enable is dropped by the caller after the last write
    task automatic write_reg(cfg_idx_t idx, longint unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge aclk);
        case (idx)
            CFG_STIFFNESS:   k_reg = value & 64'h7fffffff;
            CFG_DAMPING:     c_reg = value & 64'h7fffffff;
            CFG_REST_LENGTH: rest_reg = value & 64'h7fffffff;
            CFG_MASS_A:      ma_reg = value & 64'h7fffffff;
            CFG_MASS_B:      mb_reg = value & 64'h7fffffff;
            default: ;
        endcase
    endtask

    task automatic set_config(longint unsigned k, longint unsigned c, longint unsigned l,
                              longint unsigned ma, longint unsigned mb);
        write_reg(CFG_STIFFNESS, k);
        write_reg(CFG_DAMPING, c);
        write_reg(CFG_REST_LENGTH, l);
        write_reg(CFG_MASS_A, ma);
        write_reg(CFG_MASS_B, mb);
        cfg_wr_en <= 1'b0;
    endtask

    // drop valid and hold until the pipeline has drained
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (force_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $signed($urandom_range(4000000)) - 2000000;
            1: return $urandom;
            2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(200)) - 100;
        endcase
    endfunction

    function automatic spring_item_t rand_item();
        spring_item_t it;
        int m;
        m = $urandom_range(9);
        it.pax = rand_coord(m % 4);
        it.pay = rand_coord($urandom_range(3));
        it.pbx = (m == 9) ? it.pax : it.pax + rand_coord($urandom_range(3));
        it.pby = (m == 9) ? it.pay : it.pay + rand_coord($urandom_range(3));
        it.qax = ($urandom_range(3) == 0) ? rand_coord(1) : it.pax - rand_coord(3);
        it.qay = ($urandom_range(3) == 0) ? rand_coord(1) : it.pay - rand_coord(3);
        it.qbx = ($urandom_range(3) == 0) ? rand_coord(1) : it.pbx - rand_coord(3);
        it.qby = ($urandom_range(3) == 0) ? rand_coord(1) : it.pby - rand_coord(3);
        case ($urandom_range(5))
            0: it.dt = '0;
            1: it.dt = 31'h7fffffff;
            2: it.dt = DT_W'($urandom_range(65536, 1));
            3: it.dt = 31'd65536;
            default: it.dt = DT_W'($urandom);
        endcase
        return it;
    endfunction

    function automatic spring_item_t make_item(logic signed [31:0] ax, logic signed [31:0] ay,
                                               logic signed [31:0] bx, logic signed [31:0] by,
                                               logic [DT_W-1:0] dt);
        spring_item_t it;
        it.pax = ax; it.pay = ay; it.pbx = bx; it.pby = by;
        it.qax = ax - 32'sd1000; it.qay = ay + 32'sd500;
        it.qbx = bx + 32'sd2000; it.qby = by;
        it.dt = dt;
        return it;
    endfunction

    task automatic test_directed();
        // defaults from reset: masses 1.0, no spring
        send_item(make_item(0, 0, 32'sh10000, 0, 31'd65536));
        wait_drain();
        set_config(31'h20000, 31'h8000, 31'h18000, 65536, 131072);
        send_item(make_item(0, 0, 32'sh30000, 32'sh40000, 31'd65536));
        // coinciding bodies
        send_item(make_item(32'sh12345, -32'sh777, 32'sh12345, -32'sh777, 31'd65536));
        // zero time step
        send_item(make_item(0, 0, 32'sh10000, 32'sh10000, 31'd0));
        send_item(make_item(0, 0, 32'sh10000, 32'sh10000, 31'h7fffffff));
        // extreme positions and full-range separations
        send_item(make_item(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 31'd1));
        send_item(make_item(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 31'd1));
        send_item(make_item(32'sh7fffffff, 0, 32'sh80000000, 0, 31'd65536));
        send_item(make_item(0, 32'sh80000000, 0, 32'sh7fffffff, 31'd3));
        wait_drain();
        // zero masses, saturating constants
        set_config(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 0, 0);
        send_item(make_item(0, 0, 32'sh10000, 0, 31'd1));
        send_item(make_item(32'sh80000000, 0, 32'sh7fffffff, 0, 31'd1));
        send_item(make_item(5, 5, 5, 5, 31'd0));
        send_item(make_item(0, 0, 1, 1, 31'd65536));
        wait_drain();
        set_config(31'h7fffffff, 0, 0, 31'h7fffffff, 1);
        send_item(make_item(0, 0, 32'sh50000, -32'sh50000, 31'd65536));
        send_item(make_item(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 31'd1));
        wait_drain();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_item(rand_item());
        wait_drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_random_configs();
        // typical spring, both idle modes
        set_config(31'h30000, 31'h4000, 31'h50000, 65536, 196608);
        test_random_phase(0, 0, 160);
        test_random_phase(46, 0, 160);
        // random registers
        set_config($urandom, $urandom, $urandom, $urandom, $urandom);
        test_random_phase(0, 46, 160);
        test_random_phase(27, 27, 160);
        // extremes
        set_config(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        test_random_phase(0, 0, 150);
        set_config(0, 0, 0, 0, 0);
        test_random_phase(46, 46, 150);
        set_config($urandom_range(65536 * 8), $urandom_range(65536 * 8),
                   $urandom_range(65536 * 64), $urandom_range(65536 * 4, 1),
                   $urandom_range(65536 * 4, 1));
        test_random_phase(27, 27, 160);
        test_random_phase(0, 0, 150);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_configs();
        if (err_count == 0) begin
            $display("damped_spring_force verification clean");
        end else begin
            $display("damped_spring_force verification failed");
        end
        $finish;
    end

endmodule
